[design/abrc_pkg.sv]
// abrc_pkg: shared types and constants for the ambient backlight ramp controller
`default_nettype none

package abrc_pkg;

    localparam int LEVEL_W     = 8;
    localparam int POS_W       = 7;
    localparam int CNT_W       = 7;
    localparam int ACC_W       = 24;
    localparam int LUX_W       = 17;
    localparam int CMD_W       = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // fixed levels used by the averaging and wake paths
    localparam logic [LEVEL_W-1:0] WAKE_AUTO_LEVEL = 8'd75;
    localparam logic [LEVEL_W-1:0] AVG_TARGET_MAX  = 8'd100;
    localparam logic [LEVEL_W-1:0] AVG_TARGET_MIN  = 8'd1;
    localparam logic [LEVEL_W-1:0] AVG_LOW_LIMIT   = 8'd2;

    localparam logic [LEVEL_W-1:0] WAKE_LEVEL_RESET = 8'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_MODE = 3'd0,
        CMD_LUX      = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_DIM      = 3'd3,
        CMD_WAKE     = 3'd4
    } t_command;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAKE_USES_AUTO    = 1'b0,
        CFG_WAKE_MANUAL_LEVEL = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic               auto_enable;
        logic [LEVEL_W-1:0] manual_level;
        logic [LUX_W-1:0]   lux;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] backlight_level;
        logic               level_written;
        logic               display_off;
        logic               ramp_active;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] current_level;
        logic [LEVEL_W-1:0] written_level;
        logic [LEVEL_W-1:0] ramp_start_level;
        logic [LEVEL_W-1:0] ramp_target_level;
        logic               ramp_downward;
        logic [POS_W-1:0]   ramp_position;
        logic               ramp_running;
        logic               lcd_dimmed;
        logic               auto_mode;
        logic [CNT_W-1:0]   sample_count;
        logic [ACC_W-1:0]   lux_accumulator;
        logic [LEVEL_W-1:0] ramp_diff;
    } t_state;

endpackage

`default_nettype wire

[design/abrc_step.sv]
// abrc_step: next-state and result logic for one command
`default_nettype none

module abrc_step
    import abrc_pkg::*;
#(
    parameter int AVG_SAMPLES = 8,
    parameter int RAMP_STEPS  = 16,
    parameter int LEVEL_MIN   = 25,
    parameter int LEVEL_MAX   = 100,
    parameter int PROD_W      = 13
) (
    input  wire t_state             i_state,
    input  wire logic [PROD_W-1:0]  i_prod,
    input  wire t_in_item           i_item,
    input  wire logic               i_wake_uses_auto,
    input  wire logic [LEVEL_W-1:0] i_wake_level,
    output t_state                  o_state,
    output logic [PROD_W-1:0]       o_prod,
    output t_out_item               o_result
);

    // exact divide by constant: x / D == (x * ceil(2^(N+l)/D)) >> (N+l), l = clog2(D)
    localparam int AVG_L   = $clog2(AVG_SAMPLES);
    localparam int AVG_S   = ACC_W + AVG_L;
    localparam int AVG_Q_W = ACC_W + 1 - AVG_L;
    localparam longint unsigned AVG_M_L =
        ((64'd1 << AVG_S) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
    localparam logic [ACC_W:0] AVG_M = (ACC_W+1)'(AVG_M_L);

    localparam int RS_L = $clog2(RAMP_STEPS);
    localparam int RS_S = PROD_W + RS_L;
    localparam longint unsigned RS_M_L =
        ((64'd1 << RS_S) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);
    localparam logic [PROD_W:0] RS_M = (PROD_W+1)'(RS_M_L);

    localparam logic [CNT_W-1:0]      AVG_CNT   = CNT_W'(AVG_SAMPLES);
    localparam logic [POS_W-1:0]      RS_POS    = POS_W'(RAMP_STEPS);
    localparam logic [LEVEL_W-1:0]    L_MIN_8   = LEVEL_W'(LEVEL_MIN);
    localparam logic [LEVEL_W-1:0]    L_MAX_8   = LEVEL_W'(LEVEL_MAX);
    localparam logic signed [LEVEL_W+1:0] L_MIN_S = (LEVEL_W+2)'(LEVEL_MIN);
    localparam logic signed [LEVEL_W+1:0] L_MAX_S = (LEVEL_W+2)'(LEVEL_MAX);

    logic [ACC_W-1:0]             acc_sum;
    logic [CNT_W-1:0]             cnt_inc;
    logic [2*ACC_W:0]             avg_prod;
    logic [AVG_Q_W-1:0]           avg_q;
    logic [LEVEL_W-1:0]           avg_tgt;
    logic [2*PROD_W+1:0]          ramp_prod;
    logic [LEVEL_W-1:0]           ramp_off;
    logic signed [LEVEL_W+1:0]    ramp_lvl;
    logic signed [LEVEL_W+1:0]    tick_lvl;
    logic                         ramp_go;
    logic [LEVEL_W-1:0]           ramp_tgt;
    logic [LEVEL_W-1:0]           diff;
    logic [LEVEL_W+POS_W-1:0]     start_prod;
    logic                         wr_go;
    logic signed [LEVEL_W+1:0]    wr_req;
    logic signed [LEVEL_W+1:0]    wr_val;
    t_state                       n_st;
    logic [PROD_W-1:0]            n_prod;

    // lux averaging
    assign acc_sum  = i_state.lux_accumulator + ACC_W'(i_item.lux);
    assign cnt_inc  = i_state.sample_count + CNT_W'(1);
    assign avg_prod = acc_sum * AVG_M;
    assign avg_q    = avg_prod[AVG_S +: AVG_Q_W];

    always_comb begin
        if (avg_q < AVG_Q_W'(AVG_LOW_LIMIT)) begin
            avg_tgt = AVG_TARGET_MIN;
        end else if (avg_q > AVG_Q_W'(AVG_TARGET_MAX)) begin
            avg_tgt = AVG_TARGET_MAX;
        end else begin
            avg_tgt = avg_q[LEVEL_W-1:0];
        end
    end

    // ramp offset from the kept diff*position product
    assign ramp_prod = i_prod * RS_M;
    assign ramp_off  = ramp_prod[RS_S +: LEVEL_W];
    assign ramp_lvl  = i_state.ramp_downward
                     ? $signed({2'b00, i_state.ramp_start_level}) - $signed({2'b00, ramp_off})
                     : $signed({2'b00, i_state.ramp_start_level}) + $signed({2'b00, ramp_off});

    always_comb begin
        n_st     = i_state;
        n_prod   = i_prod;
        ramp_go  = 1'b0;
        ramp_tgt = '0;
        wr_go    = 1'b0;
        wr_req   = '0;
        tick_lvl = ramp_lvl;
        diff     = '0;
        start_prod = '0;
        wr_val   = '0;

        unique case (i_item.command)
            CMD_SET_MODE: begin
                n_st.auto_mode     = i_item.auto_enable;
                n_st.current_level = i_item.manual_level;
                wr_go  = 1'b1;
                wr_req = $signed({2'b00, i_item.manual_level});
            end
            CMD_LUX: begin
                if (i_state.auto_mode) begin
                    n_st.lux_accumulator = acc_sum;
                    n_st.sample_count    = cnt_inc;
                    if (cnt_inc >= AVG_CNT) begin
                        n_st.sample_count    = '0;
                        n_st.lux_accumulator = '0;
                        ramp_go  = !i_state.lcd_dimmed;
                        ramp_tgt = avg_tgt;
                    end
                end
            end
            CMD_TICK: begin
                if (i_state.ramp_running) begin
                    if (i_state.ramp_position < RS_POS) begin
                        n_st.ramp_position = i_state.ramp_position + POS_W'(1);
                        n_prod = i_prod + PROD_W'(i_state.ramp_diff);
                    end else begin
                        tick_lvl = $signed({2'b00, i_state.ramp_target_level});
                        n_st.ramp_position = '0;
                        n_st.ramp_running  = 1'b0;
                        n_prod = '0;
                    end
                    n_st.current_level = tick_lvl[LEVEL_W-1:0];
                    wr_go  = 1'b1;
                    wr_req = tick_lvl;
                end
            end
            CMD_DIM: begin
                n_st.lcd_dimmed = 1'b1;
                ramp_go  = 1'b1;
                ramp_tgt = '0;
            end
            CMD_WAKE: begin
                if (i_state.lcd_dimmed) begin
                    n_st.lcd_dimmed = 1'b0;
                    ramp_go  = 1'b1;
                    ramp_tgt = i_wake_uses_auto ? WAKE_AUTO_LEVEL : i_wake_level;
                end
            end
            default: begin
            end
        endcase

        // ramp start, position is kept so the product is rebuilt from it
        if (ramp_go && (n_st.current_level != ramp_tgt)) begin
            if (n_st.current_level > ramp_tgt) begin
                n_st.ramp_downward = 1'b1;
                diff = n_st.current_level - ramp_tgt;
            end else begin
                n_st.ramp_downward = 1'b0;
                diff = ramp_tgt - n_st.current_level;
            end
            n_st.ramp_diff         = diff;
            n_st.ramp_target_level = ramp_tgt;
            n_st.ramp_running      = 1'b1;
            n_st.ramp_start_level  = n_st.current_level;
            start_prod = diff * n_st.ramp_position;
            n_prod     = start_prod[PROD_W-1:0];
        end

        // level write with clamp, clamp also moves current and start levels
        if (wr_go && ($signed({2'b00, n_st.written_level}) != wr_req)) begin
            wr_val = wr_req;
            if (wr_val < L_MIN_S) begin
                wr_val = L_MIN_S;
                n_st.current_level    = L_MIN_8;
                n_st.ramp_start_level = L_MIN_8;
            end
            if (wr_val > L_MAX_S) begin
                wr_val = L_MAX_S;
                n_st.current_level    = L_MAX_8;
                n_st.ramp_start_level = L_MAX_8;
            end
            n_st.written_level = wr_val[LEVEL_W-1:0];
        end
    end

    assign o_state = n_st;
    assign o_prod  = n_prod;

    assign o_result.backlight_level = n_st.written_level;
    assign o_result.level_written   = (n_st.written_level != i_state.written_level);
    assign o_result.display_off     = n_st.lcd_dimmed;
    assign o_result.ramp_active     = n_st.ramp_running;

endmodule

`default_nettype wire

[design/ambient_backlight_ramp_controller_unit.sv]
// ambient_backlight_ramp_controller_unit: top level of the backlight ramp controller
//
//  channel   direction  handshake                   beat
//  command   in         i_in_valid / o_in_stall     t_in_item  i_in
//  result    out        o_out_valid / i_out_stall   t_out_item o_out
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
//  one command beat per cycle sustained while the result is not stalled
//  each beat passes the input register then the result register, with the step logic between
//  a stalled result holds the step register, the input register still fills behind it
//  reset (synchronous, active low) clears all level, ramp and averaging state
//  config is taken the cycle i_cfg_we is high, wake level resets to 100
`default_nettype none

module ambient_backlight_ramp_controller_unit
    import abrc_pkg::*;
#(
    parameter int AVG_SAMPLES = 8,
    parameter int RAMP_STEPS  = 16,
    parameter int LEVEL_MIN   = 25,
    parameter int LEVEL_MAX   = 100
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire t_in_item               i_in,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output t_out_item                   o_out,
    input  wire logic                   i_out_stall,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // diff*position fits this many bits since position never passes RAMP_STEPS
    localparam int PROD_W = LEVEL_W + $clog2(RAMP_STEPS + 1);

    // input register
    logic      r_in_valid;
    t_in_item  r_in;
    // result register
    logic      r_out_valid;
    t_out_item r_out;
    // controller state
    t_state              r_state;
    logic [PROD_W-1:0]   r_prod;
    logic                r_wake_uses_auto;
    logic [LEVEL_W-1:0]  r_wake_level;

    t_state              n_state;
    logic [PROD_W-1:0]   n_prod;
    t_out_item           n_out;

    logic advance;
    logic in_take;

    // the step fires when an input beat is held and the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = i_in_valid && (!r_in_valid || advance);
    assign o_in_stall = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    abrc_step #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .RAMP_STEPS  (RAMP_STEPS),
        .LEVEL_MIN   (LEVEL_MIN),
        .LEVEL_MAX   (LEVEL_MAX),
        .PROD_W      (PROD_W)
    ) u_step (
        .i_state          (r_state),
        .i_prod           (r_prod),
        .i_item           (r_in),
        .i_wake_uses_auto (r_wake_uses_auto),
        .i_wake_level     (r_wake_level),
        .o_state          (n_state),
        .o_prod           (n_prod),
        .o_result         (n_out)
    );

    // input beat register, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
        if (in_take) begin
            r_in <= i_in;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // controller state moves once per command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_prod  <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_prod  <= n_prod;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_uses_auto <= 1'b0;
            r_wake_level     <= WAKE_LEVEL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WAKE_USES_AUTO:    r_wake_uses_auto <= i_cfg_data[0];
                CFG_WAKE_MANUAL_LEVEL: r_wake_level     <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
